// File: src/npep_pkg.sv
`default_nettype none

package npep_pkg;

  // Field widths
  localparam int COLOR_W    = 24;
  localparam int FIELD_IW   = 4;
  localparam int BAN_W      = 16;
  localparam int PSIZE_W    = 5;
  localparam int COST_W     = 20;
  localparam int CHAN_W     = 8;

  // Defaults
  localparam int DEFAULT_DEPTH = 16;
  localparam int PSIZE_RESET   = 16;

  // APB register file
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-3:0] REG_PALETTE_SIZE = 1'b0;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  // Cost weights
  localparam int W_R        = 3;
  localparam int W_G        = 6;
  localparam int W_B        = 1;
  localparam int W_CHROMA   = 4;
  localparam int W_CONTRAST = 16;
  localparam int CHROMA_MAX = 128;
  localparam int LUMA_KNEE  = 72;

  // luma = floor(sum / 10) == (sum * LUMA_RECIP) >> LUMA_SHIFT for sum <= 2550
  localparam int LUMA_RECIP = 6554;
  localparam int LUMA_SHIFT = 16;
  localparam int LSUM_W     = 12;
  localparam int LPROD_W    = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_READ,
    ST_LD_WRITE,
    ST_LD_SWEEP,
    ST_LD_DRAIN,
    ST_PK_BACK,
    ST_PK_SCAN,
    ST_PK_DRAIN
  } npep_state_t;

  // What a palette read is for
  typedef enum logic [1:0] {
    KIND_OLD,
    KIND_SWEEP,
    KIND_BACK,
    KIND_ENTRY
  } npep_kind_t;

  // Read address source
  typedef enum logic [1:0] {
    SEL_LOAD,
    SEL_BACK,
    SEL_COUNT
  } npep_addr_sel_t;

  typedef struct packed {
    logic           accept;
    logic           rd_en;
    npep_addr_sel_t rd_sel;
    npep_kind_t     rd_kind;
    logic           wr_en;
    logic           pick_start;
    logic           load_result;
  } npep_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } npep_sts_t;

endpackage

`default_nettype wire

// File: src/npep_cfg.sv
`default_nettype none

module npep_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [npep_pkg::APB_AW-1:0]     paddr,
  input  wire logic [npep_pkg::APB_DW-1:0]     pwdata,
  output logic      [npep_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready,
  output logic      [npep_pkg::PSIZE_W-1:0]    psize
);

  logic [npep_pkg::PSIZE_W-1:0] psize_r;
  logic                         hit;
  logic                         wr;

  // Register decode, word addressed
  assign hit    = (paddr[npep_pkg::APB_AW-1:2] == npep_pkg::REG_PALETTE_SIZE);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready & hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= npep_pkg::PSIZE_W'(npep_pkg::PSIZE_RESET);
    end else if (wr) begin
      psize_r <= pwdata[npep_pkg::PSIZE_W-1:0];
    end
  end

  // Read back
  assign prdata = hit ? npep_pkg::APB_DW'(psize_r) : '0;
  assign psize  = psize_r;

endmodule

`default_nettype wire

// File: src/npep_ctrl.sv
`default_nettype none

module npep_ctrl #(
  parameter int PALETTE_DEPTH = npep_pkg::DEFAULT_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_command,
  input  wire logic [npep_pkg::PSIZE_W-1:0]          psize,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output npep_pkg::npep_cmd_t                        cmd,
  input  wire npep_pkg::npep_sts_t                   sts,
  output logic [$clog2(PALETTE_DEPTH)-1:0]           cnt
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int LW = (CW > npep_pkg::PSIZE_W) ? CW : npep_pkg::PSIZE_W;

  npep_pkg::npep_state_t state_r, state_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LW-1:0]         ps_ext;
  logic [CW-1:0]         n_clamp;
  logic                  out_free;

  // Entries searched: size clamped to 1..PALETTE_DEPTH
  always_comb begin
    ps_ext = LW'(psize);
    if (ps_ext == '0) begin
      n_clamp = CW'(1);
    end else if (ps_ext > LW'(PALETTE_DEPTH)) begin
      n_clamp = CW'(PALETTE_DEPTH);
    end else begin
      n_clamp = CW'(ps_ext);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npep_pkg::ST_IDLE;
      cnt_r       <= '0;
      n_r         <= CW'(PALETTE_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      npep_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == npep_pkg::CMD_PICK) begin
            cmd.pick_start = 1'b1;
            n_nxt          = n_clamp;
            state_nxt      = npep_pkg::ST_PK_BACK;
          end else begin
            state_nxt = npep_pkg::ST_LD_READ;
          end
        end
      end
      npep_pkg::ST_LD_READ: begin
        // fetch the color being replaced
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = npep_pkg::SEL_LOAD;
        cmd.rd_kind = npep_pkg::KIND_OLD;
        state_nxt   = npep_pkg::ST_LD_WRITE;
      end
      npep_pkg::ST_LD_WRITE: begin
        cmd.wr_en = 1'b1;
        cnt_nxt   = '0;
        state_nxt = npep_pkg::ST_LD_SWEEP;
      end
      npep_pkg::ST_LD_SWEEP: begin
        // refresh duplicate flags over the whole store
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = npep_pkg::SEL_COUNT;
        cmd.rd_kind = npep_pkg::KIND_SWEEP;
        cnt_nxt     = cnt_r + IW'(1);
        if (cnt_r == IW'(PALETTE_DEPTH - 1)) begin
          state_nxt = npep_pkg::ST_LD_DRAIN;
        end
      end
      npep_pkg::ST_LD_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = npep_pkg::ST_IDLE;
        end
      end
      npep_pkg::ST_PK_BACK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = npep_pkg::SEL_BACK;
        cmd.rd_kind = npep_pkg::KIND_BACK;
        cnt_nxt     = '0;
        state_nxt   = npep_pkg::ST_PK_SCAN;
      end
      npep_pkg::ST_PK_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = npep_pkg::SEL_COUNT;
        cmd.rd_kind = npep_pkg::KIND_ENTRY;
        cnt_nxt     = cnt_r + IW'(1);
        if (CW'(cnt_r) == n_r - CW'(1)) begin
          state_nxt = npep_pkg::ST_PK_DRAIN;
        end
      end
      npep_pkg::ST_PK_DRAIN: begin
        // wait for the last cost, then for room in the output register
        if (!sts.pipe_busy && out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = npep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = npep_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on result load, cleared on transfer
  always_comb begin
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> !sts.pipe_busy)
    else $error("result loaded before cost pipeline drained");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npep_pkg::ST_PK_SCAN) |-> (CW'(cnt_r) < n_r))
    else $error("scan index beyond palette size");

  a_pick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == npep_pkg::CMD_PICK))
      |=> (state_r == npep_pkg::ST_PK_BACK))
    else $error("pick transfer did not start backdrop fetch");

endmodule

`default_nettype wire

// File: src/npep_dp.sv
`default_nettype none

module npep_dp #(
  parameter int PALETTE_DEPTH = npep_pkg::DEFAULT_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire npep_pkg::npep_cmd_t                 cmd,
  input  wire logic [$clog2(PALETTE_DEPTH)-1:0]    cnt,
  input  wire logic [npep_pkg::FIELD_IW-1:0]       in_entry_index,
  input  wire logic [npep_pkg::COLOR_W-1:0]        in_entry_color,
  input  wire logic [npep_pkg::COLOR_W-1:0]        in_want_color,
  input  wire logic                                in_use_backdrop,
  input  wire logic [npep_pkg::FIELD_IW-1:0]       in_backdrop_index,
  input  wire logic [npep_pkg::BAN_W-1:0]          in_ban_mask,
  output npep_pkg::npep_sts_t                      sts,
  output logic      [npep_pkg::FIELD_IW-1:0]       out_picked_index,
  output logic      [npep_pkg::COST_W-1:0]         out_best_cost,
  output logic                                     out_ban_ignored
);

  localparam int IW  = $clog2(PALETTE_DEPTH);
  localparam int BW  = (IW > 4) ? IW : 4;
  localparam int CHW = npep_pkg::CHAN_W;
  localparam int CLW = npep_pkg::COLOR_W;
  localparam int SQW = 2 * CHW;
  localparam int PBW = 7;
  localparam int PSW = 2 * PBW + 3;

  // Index wrap modulo depth, repeated subtraction on a 4-bit value
  function automatic logic [IW-1:0] wrap_idx(input logic [npep_pkg::FIELD_IW-1:0] v);
    logic [8:0] t;
    t = 9'(v);
    for (int k = 0; k < 8; k++) begin
      if (t >= 9'(PALETTE_DEPTH)) t = t - 9'(PALETTE_DEPTH);
    end
    return t[IW-1:0];
  endfunction

  function automatic logic [CHW-1:0] absdiff(input logic [CHW-1:0] a, input logic [CHW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CHW-1:0] chroma(input logic [CLW-1:0] c);
    logic [CHW-1:0] r, g, b, hi, lo, span;
    r  = c[23:16];
    g  = c[15:8];
    b  = c[7:0];
    hi = (r > g) ? r : g;
    lo = (r < g) ? r : g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    span = hi - lo;
    return (span > CHW'(npep_pkg::CHROMA_MAX)) ? CHW'(npep_pkg::CHROMA_MAX) : span;
  endfunction

  // Item registers
  logic [IW-1:0]           ld_idx_r, bd_idx_r;
  logic [CLW-1:0]          ld_color_r, want_r;
  logic                    use_bd_r;
  logic [npep_pkg::BAN_W-1:0] ban_r;

  // Palette store and duplicate tracking
  logic [CLW-1:0]          mem [PALETTE_DEPTH];
  logic [CLW-1:0]          rdata_r, old_r;
  logic [IW-1:0]           rd_addr;
  logic [PALETTE_DEPTH-1:0] canon_r;
  logic                    seen_new_r, seen_old_r;

  // Pipeline
  logic                    v1_r, v2_r, v3_r, v4_r, v5_r;
  npep_pkg::npep_kind_t    kind1_r, kind2_r, kind3_r;
  logic [IW-1:0]           idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;
  logic                    cand2_r, cand3_r, cand4_r, cand5_r;
  logic                    ban2_r, ban3_r, ban4_r, ban5_r;
  logic [CHW-1:0]          dr2_r, dg2_r, db2_r, dc2_r;
  logic [npep_pkg::LSUM_W-1:0]  lsum2_r;
  logic [SQW-1:0]          sqr3_r, sqg3_r, sqb3_r, sqc3_r;
  logic [npep_pkg::LPROD_W-1:0] lprod3_r;
  logic [npep_pkg::COST_W-1:0]  w4_r, cost5_r;
  logic [PBW-1:0]          pb4_r;
  logic [CHW-1:0]          bd_luma_r;

  // Best trackers: over unbanned candidates and over all candidates
  logic                    any_ok_r, any_all_r;
  logic [npep_pkg::COST_W-1:0] best_ok_r, best_all_r;
  logic [IW-1:0]           idx_ok_r, idx_all_r;

  // Result register
  logic [npep_pkg::FIELD_IW-1:0] out_idx_r;
  logic [npep_pkg::COST_W-1:0]   out_cost_r;
  logic                          out_ign_r;

  logic                    sweep1, fwd1, hit_new, hit_old, ban1;
  logic [BW-1:0]           iext1;
  logic [npep_pkg::COST_W-1:0] w3;
  logic [CHW-1:0]          luma3, ld3;
  logic [PBW-1:0]          pb3;
  logic [PSW-1:0]          pen4;
  logic [npep_pkg::COST_W-1:0] cost4;
  logic                    upd_ok, upd_all;

  // Latch item fields on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ld_idx_r   <= wrap_idx(in_entry_index);
      ld_color_r <= in_entry_color;
      want_r     <= in_want_color;
      use_bd_r   <= in_use_backdrop;
      bd_idx_r   <= wrap_idx(in_backdrop_index);
      ban_r      <= in_ban_mask;
    end
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      npep_pkg::SEL_LOAD:  rd_addr = ld_idx_r;
      npep_pkg::SEL_BACK:  rd_addr = bd_idx_r;
      npep_pkg::SEL_COUNT: rd_addr = cnt;
      default:             rd_addr = cnt;
    endcase
  end

  // Palette memory, one port used per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[ld_idx_r] <= ld_color_r;
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  // Old color captured before overwrite
  always_ff @(posedge clk) begin
    if (cmd.wr_en) old_r <= rdata_r;
  end

  // Stage 1: read data back
  assign sweep1  = v1_r && (kind1_r == npep_pkg::KIND_SWEEP);
  assign fwd1    = v1_r && ((kind1_r == npep_pkg::KIND_BACK) ||
                            (kind1_r == npep_pkg::KIND_ENTRY));
  assign hit_new = (rdata_r == ld_color_r);
  assign hit_old = (rdata_r == old_r);
  assign iext1   = BW'(idx1_r);
  assign ban1    = ((iext1 >> 4) == '0) && ban_r[iext1[3:0]];

  // Canonical flags: only entries holding the old or new color can change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canon_r    <= '1;
      seen_new_r <= 1'b0;
      seen_old_r <= 1'b0;
    end else if (cmd.wr_en) begin
      seen_new_r <= 1'b0;
      seen_old_r <= 1'b0;
    end else if (sweep1) begin
      if (hit_new) begin
        canon_r[idx1_r] <= !seen_new_r;
        seen_new_r      <= 1'b1;
      end else if (hit_old) begin
        canon_r[idx1_r] <= !seen_old_r;
        seen_old_r      <= 1'b1;
      end
    end
  end

  // Stage 3 combinational: weighted sum and contrast base
  assign w3 = npep_pkg::COST_W'(sqr3_r) * npep_pkg::COST_W'(npep_pkg::W_R)
            + npep_pkg::COST_W'(sqg3_r) * npep_pkg::COST_W'(npep_pkg::W_G)
            + npep_pkg::COST_W'(sqb3_r) * npep_pkg::COST_W'(npep_pkg::W_B)
            + npep_pkg::COST_W'(sqc3_r) * npep_pkg::COST_W'(npep_pkg::W_CHROMA);
  assign luma3 = lprod3_r[npep_pkg::LUMA_SHIFT +: CHW];
  assign ld3   = absdiff(luma3, bd_luma_r);
  assign pb3   = (use_bd_r && (ld3 < CHW'(npep_pkg::LUMA_KNEE)))
               ? PBW'(CHW'(npep_pkg::LUMA_KNEE) - ld3) : '0;

  // Stage 4 combinational: penalty square and total
  assign pen4  = PSW'(pb4_r) * PSW'(pb4_r) * PSW'(npep_pkg::W_CONTRAST);
  assign cost4 = w4_r + npep_pkg::COST_W'(pen4);

  // Stage 5 combinational: running minimum, ties keep the earlier entry
  assign upd_all = v5_r && cand5_r && (!any_all_r || (cost5_r < best_all_r));
  assign upd_ok  = v5_r && cand5_r && !ban5_r && (!any_ok_r || (cost5_r < best_ok_r));

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= fwd1;
      v3_r <= v2_r;
      v4_r <= v3_r && (kind3_r == npep_pkg::KIND_ENTRY);
      v5_r <= v4_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    kind1_r  <= cmd.rd_kind;
    idx1_r   <= rd_addr;
    // stage 1 -> 2: differences, chroma, luma sum
    kind2_r  <= kind1_r;
    idx2_r   <= idx1_r;
    cand2_r  <= canon_r[idx1_r];
    ban2_r   <= ban1;
    dr2_r    <= absdiff(want_r[23:16], rdata_r[23:16]);
    dg2_r    <= absdiff(want_r[15:8], rdata_r[15:8]);
    db2_r    <= absdiff(want_r[7:0], rdata_r[7:0]);
    dc2_r    <= absdiff(chroma(want_r), chroma(rdata_r));
    lsum2_r  <= npep_pkg::LSUM_W'(rdata_r[23:16]) * npep_pkg::LSUM_W'(npep_pkg::W_R)
              + npep_pkg::LSUM_W'(rdata_r[15:8]) * npep_pkg::LSUM_W'(npep_pkg::W_G)
              + npep_pkg::LSUM_W'(rdata_r[7:0]) * npep_pkg::LSUM_W'(npep_pkg::W_B);
    // stage 2 -> 3: squares and luma scaling
    kind3_r  <= kind2_r;
    idx3_r   <= idx2_r;
    cand3_r  <= cand2_r;
    ban3_r   <= ban2_r;
    sqr3_r   <= SQW'(dr2_r) * SQW'(dr2_r);
    sqg3_r   <= SQW'(dg2_r) * SQW'(dg2_r);
    sqb3_r   <= SQW'(db2_r) * SQW'(db2_r);
    sqc3_r   <= SQW'(dc2_r) * SQW'(dc2_r);
    lprod3_r <= npep_pkg::LPROD_W'(lsum2_r) * npep_pkg::LPROD_W'(npep_pkg::LUMA_RECIP);
    // stage 3 -> 4
    idx4_r   <= idx3_r;
    cand4_r  <= cand3_r;
    ban4_r   <= ban3_r;
    w4_r     <= w3;
    pb4_r    <= pb3;
    // stage 4 -> 5
    idx5_r   <= idx4_r;
    cand5_r  <= cand4_r;
    ban5_r   <= ban4_r;
    cost5_r  <= cost4;
  end

  // Backdrop luma, taken from the first item of a pick
  always_ff @(posedge clk) begin
    if (v3_r && (kind3_r == npep_pkg::KIND_BACK)) bd_luma_r <= luma3;
  end

  // Best trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_ok_r  <= 1'b0;
      any_all_r <= 1'b0;
    end else if (cmd.pick_start) begin
      any_ok_r  <= 1'b0;
      any_all_r <= 1'b0;
    end else begin
      if (upd_ok)  any_ok_r  <= 1'b1;
      if (upd_all) any_all_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_ok) begin
      best_ok_r <= cost5_r;
      idx_ok_r  <= idx5_r;
    end
    if (upd_all) begin
      best_all_r <= cost5_r;
      idx_all_r  <= idx5_r;
    end
  end

  // Output register; the ban is dropped when no unbanned candidate exists
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_idx_r  <= any_ok_r ? npep_pkg::FIELD_IW'(idx_ok_r)
                             : npep_pkg::FIELD_IW'(idx_all_r);
      out_cost_r <= any_ok_r ? best_ok_r : best_all_r;
      out_ign_r  <= !any_ok_r;
    end
  end

  assign out_picked_index = out_idx_r;
  assign out_best_cost    = out_cost_r;
  assign out_ban_ignored  = out_ign_r;

  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r;

endmodule

`default_nettype wire

// File: src/nearest_palette_entry_pick_unit.sv
// Nearest palette entry pick unit.
//
// Input channel (in_valid/in_ready): one transfer carries a command. A load
// writes in_entry_color to slot in_entry_index; a pick searches the first
// palette_size entries for the canonical entry closest to in_want_color.
// Result channel (out_valid/out_ready): one transfer per pick, none per load.
// Configuration: APB register palette_size at byte address 0, reset value 16.
//
// Timing: one item at a time. A pick makes one backdrop read, then one palette
// read per entry of the clamped palette_size through a five-stage cost
// pipeline, then drains the pipeline. A load makes an old-color read and a
// write, then sweeps the whole store over its single read port to refresh
// the duplicate flags.
//
// The result sits in an output register; the next item is taken while it
// waits. A pick that finishes while the receiver still stalls holds until the
// register frees. Reset empties the pipeline and output, restores
// palette_size; palette contents are undefined until loaded.
`default_nettype none

module nearest_palette_entry_pick_unit #(
  parameter int PALETTE_DEPTH = npep_pkg::DEFAULT_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_command,
  input  wire logic [npep_pkg::FIELD_IW-1:0]      in_entry_index,
  input  wire logic [npep_pkg::COLOR_W-1:0]       in_entry_color,
  input  wire logic [npep_pkg::COLOR_W-1:0]       in_want_color,
  input  wire logic                               in_use_backdrop,
  input  wire logic [npep_pkg::FIELD_IW-1:0]      in_backdrop_index,
  input  wire logic [npep_pkg::BAN_W-1:0]         in_ban_mask,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [npep_pkg::FIELD_IW-1:0]      out_picked_index,
  output logic      [npep_pkg::COST_W-1:0]        out_best_cost,
  output logic                                    out_ban_ignored,
  // APB configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [npep_pkg::APB_AW-1:0]        paddr,
  input  wire logic [npep_pkg::APB_DW-1:0]        pwdata,
  output logic      [npep_pkg::APB_DW-1:0]        prdata,
  output logic                                    pready
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  npep_pkg::npep_cmd_t          cmd;
  npep_pkg::npep_sts_t          sts;
  logic [IW-1:0]                cnt;
  logic [npep_pkg::PSIZE_W-1:0] psize;

  npep_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .psize   (psize)
  );

  npep_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .psize      (psize),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts),
    .cnt        (cnt)
  );

  npep_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cnt               (cnt),
    .in_entry_index    (in_entry_index),
    .in_entry_color    (in_entry_color),
    .in_want_color     (in_want_color),
    .in_use_backdrop   (in_use_backdrop),
    .in_backdrop_index (in_backdrop_index),
    .in_ban_mask       (in_ban_mask),
    .sts               (sts),
    .out_picked_index  (out_picked_index),
    .out_best_cost     (out_best_cost),
    .out_ban_ignored   (out_ban_ignored)
  );

endmodule

`default_nettype wire

// File: tb/sv/nearest_palette_entry_pick_unit_tb.sv
`timescale 1ns / 1ps

module nearest_palette_entry_pick_unit_tb;

  localparam int DEPTH = npep_pkg::DEFAULT_DEPTH;

  // One input transfer, all fields as the block sees them
  typedef struct packed {
    logic                          command;
    logic [npep_pkg::FIELD_IW-1:0] entry_index;
    logic [npep_pkg::COLOR_W-1:0]  entry_color;
    logic [npep_pkg::COLOR_W-1:0]  want_color;
    logic                          use_backdrop;
    logic [npep_pkg::FIELD_IW-1:0] backdrop_index;
    logic [npep_pkg::BAN_W-1:0]    ban_mask;
  } palette_op_t;

  localparam int OP_W = $bits(palette_op_t);

  // One result transfer
  typedef struct packed {
    logic [npep_pkg::FIELD_IW-1:0] picked_index;
    logic [npep_pkg::COST_W-1:0]   best_cost;
    logic                          ban_ignored;
  } pick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_command = npep_pkg::CMD_LOAD;
  logic [npep_pkg::FIELD_IW-1:0] in_entry_index = '0;
  logic [npep_pkg::COLOR_W-1:0]  in_entry_color = '0;
  logic [npep_pkg::COLOR_W-1:0]  in_want_color = '0;
  logic                          in_use_backdrop = 1'b0;
  logic [npep_pkg::FIELD_IW-1:0] in_backdrop_index = '0;
  logic [npep_pkg::BAN_W-1:0]    in_ban_mask = '0;

  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [npep_pkg::FIELD_IW-1:0] out_picked_index;
  logic [npep_pkg::COST_W-1:0]   out_best_cost;
  logic                          out_ban_ignored;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [npep_pkg::APB_AW-1:0]   paddr = '0;
  logic [npep_pkg::APB_DW-1:0]   pwdata = '0;
  logic [npep_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  // Shadow state of the block
  logic [npep_pkg::COLOR_W-1:0]  palette_shadow [DEPTH];
  logic [npep_pkg::PSIZE_W-1:0]  size_shadow = npep_pkg::PSIZE_W'(npep_pkg::PSIZE_RESET);

  pick_result_t pending_picks [$];
  int           err_cnt = 0;
  bit           in_idle_en = 1'b1;
  bit           out_idle_en = 1'b1;
  int           hold_req = 0;
  int           hold_left = 0;

  always #2 clk = ~clk;

  nearest_palette_entry_pick_unit #(
    .PALETTE_DEPTH(DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_entry_color   (in_entry_color),
    .in_want_color    (in_want_color),
    .in_use_backdrop  (in_use_backdrop),
    .in_backdrop_index(in_backdrop_index),
    .in_ban_mask      (in_ban_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_picked_index (out_picked_index),
    .out_best_cost    (out_best_cost),
    .out_ban_ignored  (out_ban_ignored),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Cost arithmetic
  // ---------------------------------------------------------------------------

  function automatic int rgb_distance(logic [npep_pkg::COLOR_W-1:0] a,
                                      logic [npep_pkg::COLOR_W-1:0] b);
    int dr, dg, db;
    dr = int'(a[23:16]) - int'(b[23:16]);
    dg = int'(a[15:8]) - int'(b[15:8]);
    db = int'(a[7:0]) - int'(b[7:0]);
    return npep_pkg::W_R * dr * dr + npep_pkg::W_G * dg * dg + npep_pkg::W_B * db * db;
  endfunction

  // max minus min channel, clamped
  function automatic int chroma_span(logic [npep_pkg::COLOR_W-1:0] c);
    int r, g, b, hi, lo;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    hi = (r > g) ? r : g;
    lo = (r < g) ? r : g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    return (hi - lo > npep_pkg::CHROMA_MAX) ? npep_pkg::CHROMA_MAX : hi - lo;
  endfunction

  function automatic int luma_level(logic [npep_pkg::COLOR_W-1:0] c);
    return (3 * int'(c[23:16]) + 6 * int'(c[15:8]) + int'(c[7:0])) / 10;
  endfunction

  // penalty grows as the candidate's luma nears the backdrop's
  function automatic int contrast_loss(logic [npep_pkg::COLOR_W-1:0] c,
                                       logic [npep_pkg::COLOR_W-1:0] bd);
    int d;
    d = luma_level(c) - luma_level(bd);
    if (d < 0) d = -d;
    return (d >= npep_pkg::LUMA_KNEE) ? 0 :
           npep_pkg::W_CONTRAST * (npep_pkg::LUMA_KNEE - d) * (npep_pkg::LUMA_KNEE - d);
  endfunction

  // Best canonical entry; a second pass drops the ban when nothing survived it
  function automatic pick_result_t predict_pick(palette_op_t op);
    pick_result_t                 res;
    int                           n, cost, best, best_i, dc;
    bit                           found, canon, ignored;
    logic [npep_pkg::COLOR_W-1:0] bd_color;
    n = size_shadow;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    bd_color = palette_shadow[op.backdrop_index];
    found = 1'b0;
    ignored = 1'b0;
    best = 0;
    best_i = 0;
    for (int pass = 0; pass < 2 && !found; pass++) begin
      ignored = (pass == 1);
      for (int i = 0; i < n; i++) begin
        canon = 1'b1;
        for (int j = 0; j < i; j++)
          if (palette_shadow[j] == palette_shadow[i]) canon = 1'b0;
        if (canon && !(pass == 0 && i < npep_pkg::BAN_W && op.ban_mask[i])) begin
          dc = chroma_span(op.want_color) - chroma_span(palette_shadow[i]);
          cost = rgb_distance(op.want_color, palette_shadow[i])
               + npep_pkg::W_CHROMA * dc * dc;
          if (op.use_backdrop) cost += contrast_loss(palette_shadow[i], bd_color);
          if (!found || cost < best) begin
            best = cost;
            best_i = i;
            found = 1'b1;
          end
        end
      end
    end
    res.picked_index = best_i[npep_pkg::FIELD_IW-1:0];
    res.best_cost = best[npep_pkg::COST_W-1:0];
    res.ban_ignored = ignored;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic palette_op_t mk_load(int idx, logic [npep_pkg::COLOR_W-1:0] color);
    palette_op_t op;
    op = OP_W'({$urandom, $urandom, $urandom});
    op.command = npep_pkg::CMD_LOAD;
    op.entry_index = idx[npep_pkg::FIELD_IW-1:0];
    op.entry_color = color;
    return op;
  endfunction

  function automatic palette_op_t mk_pick(logic [npep_pkg::COLOR_W-1:0] want, bit bd,
                                          int bd_idx, logic [npep_pkg::BAN_W-1:0] ban);
    palette_op_t op;
    op = OP_W'({$urandom, $urandom, $urandom});
    op.command = npep_pkg::CMD_PICK;
    op.want_color = want;
    op.use_backdrop = bd;
    op.backdrop_index = bd_idx[npep_pkg::FIELD_IW-1:0];
    op.ban_mask = ban;
    return op;
  endfunction

  // Random item; loads often copy an entry to make duplicates, picks aim near entries
  function automatic palette_op_t random_op(int pick_pct);
    palette_op_t                  op;
    logic [npep_pkg::COLOR_W-1:0] base;
    op = OP_W'({$urandom, $urandom, $urandom});
    base = palette_shadow[$urandom_range(DEPTH - 1)];
    if ($urandom_range(99) < pick_pct) begin
      op.command = npep_pkg::CMD_PICK;
      case ($urandom_range(7))
        0:       op.want_color = base;
        1, 2:    op.want_color = base ^ npep_pkg::COLOR_W'($urandom & 24'h0F0F0F);
        3:       op.want_color = $urandom_range(1) ? '1 : '0;
        default: op.want_color = npep_pkg::COLOR_W'($urandom);
      endcase
      case ($urandom_range(9))
        0:       op.ban_mask = '0;
        1:       op.ban_mask = '1;
        2, 3:    op.ban_mask = ~(npep_pkg::BAN_W'(1) << $urandom_range(npep_pkg::BAN_W - 1));
        4:       op.ban_mask = npep_pkg::BAN_W'($urandom & $urandom);
        default: op.ban_mask = npep_pkg::BAN_W'($urandom);
      endcase
    end else begin
      op.command = npep_pkg::CMD_LOAD;
      case ($urandom_range(9))
        0, 1, 2: op.entry_color = base;
        3:       op.entry_color = $urandom_range(1) ? '1 : '0;
        default: op.entry_color = npep_pkg::COLOR_W'($urandom);
      endcase
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one item and wait for its transfer; called at a rising edge
  task automatic send_op(palette_op_t op);
    int gap;
    if (in_idle_en && $urandom_range(99) < 16) begin
      gap = $urandom_range(8, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= op.command;
    in_entry_index    <= op.entry_index;
    in_entry_color    <= op.entry_color;
    in_want_color     <= op.want_color;
    in_use_backdrop   <= op.use_backdrop;
    in_backdrop_index <= op.backdrop_index;
    in_ban_mask       <= op.ban_mask;
    do @(posedge clk); while (!in_ready);
    if (op.command == npep_pkg::CMD_LOAD)
      palette_shadow[op.entry_index] = op.entry_color;
    else
      pending_picks.push_back(predict_pick(op));
  endtask

  // Drop valid, wait for every pick result, then let a trailing load finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
  endtask

  // APB write of palette_size, then read it back
  task automatic write_palette_size(int value);
    logic [npep_pkg::APB_DW-1:0] wval;
    wval = npep_pkg::APB_DW'(value)
         & ((npep_pkg::APB_DW'(1) << npep_pkg::PSIZE_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {npep_pkg::REG_PALETTE_SIZE, 2'b00};
    pwdata  <= wval;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_shadow = wval[npep_pkg::PSIZE_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== wval) begin
      $error("palette_size readback: expected %0d, got %0d", wval, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus requested long hold-offs
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(out_idle_en && $urandom_range(99) < 16);
    end
  end

  // Compare each result transfer with the oldest predicted pick
  always @(posedge clk) begin
    pick_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_picks.size() == 0) begin
        $error("result transfer with no pick outstanding");
        err_cnt++;
      end else begin
        exp_res = pending_picks.pop_front();
        if (out_picked_index !== exp_res.picked_index) begin
          $error("picked_index: expected %0d, got %0d", exp_res.picked_index,
                 out_picked_index);
          err_cnt++;
        end
        if (out_best_cost !== exp_res.best_cost) begin
          $error("best_cost: expected %0d, got %0d", exp_res.best_cost, out_best_cost);
          err_cnt++;
        end
        if (out_ban_ignored !== exp_res.ban_ignored) begin
          $error("ban_ignored: expected %0d, got %0d", exp_res.ban_ignored,
                 out_ban_ignored);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every slot, then picks at the corners: duplicates, ties, full ban, backdrop
  task automatic test_directed();
    logic [npep_pkg::COLOR_W-1:0] colors [DEPTH];
    colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
               24'h0000FF, 24'hFF0000, 24'h818080, 24'h7F8080,
               24'h404040, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
               24'h000000, 24'h123456, 24'hFEDCBA, 24'hA5A5A5};
    for (int i = 0; i < DEPTH; i++) send_op(mk_load(i, colors[i]));
    // black matches slot 0, its duplicate in slot 12 never competes
    send_op(mk_pick(24'h000000, 1'b0, 0, 16'h0000));
    // everything banned, second pass without the ban
    send_op(mk_pick(24'hFFFFFF, 1'b0, 0, 16'hFFFF));
    // equal cost on slots 6 and 7, lower index wins
    send_op(mk_pick(24'h808080, 1'b0, 0, 16'h0000));
    // original red banned, its duplicate must not stand in
    send_op(mk_pick(24'hFF0000, 1'b0, 0, 16'h0004));
    // only a duplicate left unbanned counts as all banned
    send_op(mk_pick(24'h808080, 1'b0, 0, 16'hFFDF));
    // dark want on a black backdrop
    send_op(mk_pick(24'h000000, 1'b1, 0, 16'h0000));
    send_op(mk_pick(24'hFFFFFF, 1'b1, 15, 16'h0000));
    send_op(mk_pick(24'h123456, 1'b1, 1, 16'h8001));
    wait_idle();
  endtask

  // Walk palette_size through its extremes and out-of-range codes
  task automatic test_palette_sizes();
    int sizes [6];
    sizes = '{1, 0, 31, 17, 2, 16};
    foreach (sizes[k]) begin
      write_palette_size(sizes[k]);
      // backdrop in the last slot, past the searched range for the small sizes
      send_op(mk_pick(npep_pkg::COLOR_W'($urandom), 1'b1, DEPTH - 1,
                      npep_pkg::BAN_W'($urandom)));
      for (int i = 0; i < 8; i++) send_op(random_op(70));
      wait_idle();
    end
  endtask

  // Long receiver hold while items keep coming, then a full drain
  task automatic test_backpressure();
    hold_req = 400;
    for (int i = 0; i < 16; i++) send_op(random_op(70));
    wait_idle();
  endtask

  // Bulk random traffic in chunks, each under a new palette_size
  task automatic test_random();
    int pick_sz;
    for (int c = 0; c < 8; c++) begin
      case ($urandom_range(3))
        0:       pick_sz = 1;
        1:       pick_sz = DEPTH;
        default: pick_sz = $urandom_range((1 << npep_pkg::PSIZE_W) - 1);
      endcase
      write_palette_size(pick_sz);
      // one chunk runs flat out on both sides
      in_idle_en = (c != 3);
      out_idle_en = (c != 3);
      for (int i = 0; i < 250; i++) send_op(random_op(60));
      wait_idle();
    end
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_palette_sizes();
    test_backpressure();
    test_random();
    wait_idle();
    if (err_cnt == 0 && pending_picks.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
src/npep_pkg.sv
src/npep_cfg.sv
src/npep_ctrl.sv
src/npep_dp.sv
src/nearest_palette_entry_pick_unit.sv
tb/sv/nearest_palette_entry_pick_unit_tb.sv
